// ===== rtl/core/langevin_verlet_atom_update_assert.svh =====
// assertion macros for the langevin verlet atom update block
// no dependencies; included by the top level
`ifndef LANGEVIN_VERLET_ATOM_UPDATE_ASSERT_SVH
`define LANGEVIN_VERLET_ATOM_UPDATE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LVAU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication with a delay given by the argument n
`define LVAU_ASSERT_LAT(label, clk, rst_n, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lvau_pkg.sv =====
// types, constants and fixed-point helpers for the langevin verlet atom update
// no dependencies
`timescale 1ns / 1ps

package lvau_pkg;

  localparam int NumTypes    = 2;   // atom types in use, 1 or 2
  localparam int NumCoefSets = 2;   // coefficient sets in the register map
  localparam int Dims        = 3;   // components that are integrated, 1 to 3
  localparam int NumComp     = 3;   // components carried on the ports
  localparam int CfgIdxW     = 3;
  localparam int Latency     = 7;   // accept edge to result cycle
  localparam int FracBits    = 16;

  localparam logic signed [63:0] RoundBias = 64'sd32768;
  localparam logic signed [16:0] NoiseCenter = 17'sd32768;

  typedef enum logic [CfgIdxW-1:0] {
    RegTimeStep     = 3'd0,
    RegHalfKickT0   = 3'd1,
    RegDragT0       = 3'd2,
    RegNoiseAmpT0   = 3'd3,
    RegHalfKickT1   = 3'd4,
    RegDragT1       = 3'd5,
    RegNoiseAmpT1   = 3'd6
  } cfg_reg_e;

  typedef logic [0:0] kind_t;

  typedef struct packed {
    logic [30:0]        half_kick;
    logic signed [31:0] drag;
    logic [30:0]        noise_amp;
  } coef_t;

  // q16.16 product rounding: add half an lsb, floor shift
  function automatic logic signed [47:0] round_q16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + RoundBias) >>> FracBits;
    return t[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/langevin_verlet_atom_update.sv =====
// langevin velocity verlet atom update, q16.16, seven-stage pipeline
// depends on lvau_pkg and langevin_verlet_atom_update_assert.svh
//
//  channel   handshake                       payload
//  -------   -----------------------------   --------------------------------------
//  command   start_i, busy_o                 command, atom_kind, vel/frc/aux x,y,z
//  result    done_o (one-cycle strobe)       new_vel x,y,z, out x,y,z
//  config    cfg_valid_i, cfg_ready_o        cfg_index_i, cfg_data_i
//
// one atom per cycle; each result passes through capture, then multiply, round,
// sum/saturate, and the same again for the dependent half.
// busy_o stays low: the pipeline never stalls, since results cannot be held off.
// reset clears the valid bits and zeroes all coefficient registers.
// config is taken every cycle (cfg_ready_o high); index 7 is ignored.
`timescale 1ns / 1ps

module langevin_verlet_atom_update (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                command_i,
  input  logic                atom_kind_i,
  input  logic signed [31:0]  vel_x_i,
  input  logic signed [31:0]  vel_y_i,
  input  logic signed [31:0]  vel_z_i,
  input  logic signed [31:0]  frc_x_i,
  input  logic signed [31:0]  frc_y_i,
  input  logic signed [31:0]  frc_z_i,
  input  logic signed [31:0]  aux_x_i,
  input  logic signed [31:0]  aux_y_i,
  input  logic signed [31:0]  aux_z_i,
  output logic                done_o,
  output logic signed [31:0]  new_vel_x_o,
  output logic signed [31:0]  new_vel_y_o,
  output logic signed [31:0]  new_vel_z_o,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

`include "langevin_verlet_atom_update_assert.svh"

  localparam int NC = lvau_pkg::NumComp;

  // ---------------- configuration registers ----------------
  logic [30:0]      time_step_q;
  lvau_pkg::coef_t  coef_q [lvau_pkg::NumCoefSets];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= '0;
      for (int t = 0; t < lvau_pkg::NumCoefSets; t++) begin
        coef_q[t] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (lvau_pkg::cfg_reg_e'(cfg_index_i))
        lvau_pkg::RegTimeStep:   time_step_q            <= cfg_data_i[30:0];
        lvau_pkg::RegHalfKickT0: coef_q[0].half_kick    <= cfg_data_i[30:0];
        lvau_pkg::RegDragT0:     coef_q[0].drag         <= cfg_data_i;
        lvau_pkg::RegNoiseAmpT0: coef_q[0].noise_amp    <= cfg_data_i[30:0];
        lvau_pkg::RegHalfKickT1: coef_q[1].half_kick    <= cfg_data_i[30:0];
        lvau_pkg::RegDragT1:     coef_q[1].drag         <= cfg_data_i;
        lvau_pkg::RegNoiseAmpT1: coef_q[1].noise_amp    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // ---------------- control pipe ----------------
  logic                 accept;
  logic                 vld_q  [1:lvau_pkg::Latency];
  logic                 cmd_q  [1:lvau_pkg::Latency];
  lvau_pkg::kind_t      kind_q [1:4];
  lvau_pkg::kind_t      kind_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // clamp the type to the last one in use
  always_comb begin
    if (32'(atom_kind_i) > 32'(lvau_pkg::NumTypes - 1)) begin
      kind_d = lvau_pkg::kind_t'(lvau_pkg::NumTypes - 1);
    end else begin
      kind_d = lvau_pkg::kind_t'(atom_kind_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= lvau_pkg::Latency; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[1] <= accept;
      for (int s = 2; s <= lvau_pkg::Latency; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q[1]  <= command_i;
      kind_q[1] <= kind_d;
    end
    for (int s = 2; s <= lvau_pkg::Latency; s++) begin
      if (vld_q[s-1]) begin
        cmd_q[s] <= cmd_q[s-1];
      end
    end
    for (int s = 2; s <= 4; s++) begin
      if (vld_q[s-1]) begin
        kind_q[s] <= kind_q[s-1];
      end
    end
  end

  // ---------------- lane datapath ----------------
  // first half: cmd 0 -> new velocity, cmd 1 -> new force
  // second half: cmd 0 -> new position, cmd 1 -> new velocity
  logic signed [31:0] vel_in [NC];
  logic signed [31:0] frc_in [NC];
  logic signed [31:0] aux_in [NC];

  assign vel_in[0] = vel_x_i;
  assign vel_in[1] = vel_y_i;
  assign vel_in[2] = vel_z_i;
  assign frc_in[0] = frc_x_i;
  assign frc_in[1] = frc_y_i;
  assign frc_in[2] = frc_z_i;
  assign aux_in[0] = aux_x_i;
  assign aux_in[1] = aux_y_i;
  assign aux_in[2] = aux_z_i;

  // stage 1: captured operands
  logic signed [31:0] v1_q [NC];
  logic signed [31:0] f1_q [NC];
  logic signed [31:0] a1_q [NC];
  // stage 2: first products; b1 is the first sum base, b2 the second
  logic signed [63:0] p1_q [NC];
  logic signed [63:0] p2_q [NC];
  logic signed [31:0] b1_2_q [NC];
  logic signed [31:0] b2_2_q [NC];
  // stage 3: rounded products
  logic signed [47:0] r1_q [NC];
  logic signed [47:0] r2_q [NC];
  logic signed [31:0] b1_3_q [NC];
  logic signed [31:0] b2_3_q [NC];
  // stage 4: first result
  logic signed [31:0] fst_4_q [NC];
  logic signed [31:0] b1_4_q [NC];
  logic signed [31:0] b2_4_q [NC];
  // stage 5: second product
  logic signed [63:0] p3_q [NC];
  logic signed [31:0] fst_5_q [NC];
  logic signed [31:0] b1_5_q [NC];
  logic signed [31:0] b2_5_q [NC];
  // stage 6: rounded second product
  logic signed [47:0] r3_q [NC];
  logic signed [31:0] fst_6_q [NC];
  logic signed [31:0] b1_6_q [NC];
  logic signed [31:0] b2_6_q [NC];
  // stage 7: outputs
  logic signed [31:0] nv_q [NC];
  logic signed [31:0] o_q  [NC];

  logic signed [63:0] p1_d   [NC];
  logic signed [48:0] p2_w   [NC];
  logic signed [31:0] mul_a  [NC];
  logic signed [31:0] mul_b  [NC];
  logic signed [31:0] na_op  [NC];
  logic signed [16:0] u_c    [NC];
  logic signed [49:0] sum1   [NC];
  logic signed [31:0] mul_c  [NC];
  logic signed [63:0] p3_d   [NC];
  logic signed [48:0] sum2   [NC];
  logic signed [31:0] snd    [NC];
  logic signed [31:0] nv_d   [NC];
  logic signed [31:0] o_d    [NC];

  lvau_pkg::coef_t    coef_s2;
  lvau_pkg::coef_t    coef_s5;

  assign coef_s2 = coef_q[kind_q[1]];
  assign coef_s5 = coef_q[kind_q[4]];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      // stage 2 operands
      mul_a[c] = cmd_q[1] ? v1_q[c] : f1_q[c];
      mul_b[c] = cmd_q[1] ? coef_s2.drag : $signed({1'b0, coef_s2.half_kick});
      na_op[c] = cmd_q[1] ? $signed({1'b0, coef_s2.noise_amp}) : 32'sd0;
      u_c[c]   = $signed({1'b0, a1_q[c][15:0]}) - lvau_pkg::NoiseCenter;
      p1_d[c]  = mul_a[c] * mul_b[c];
      p2_w[c]  = na_op[c] * u_c[c];
      // stage 4 sum
      sum1[c]  = {{18{b1_3_q[c][31]}}, b1_3_q[c]} + {{2{r1_q[c][47]}}, r1_q[c]}
               + {{2{r2_q[c][47]}}, r2_q[c]};
      // stage 5 operand
      mul_c[c] = cmd_q[4] ? $signed({1'b0, coef_s5.half_kick})
                          : $signed({1'b0, time_step_q});
      p3_d[c]  = fst_4_q[c] * mul_c[c];
      // stage 7 sum
      sum2[c]  = {{17{b2_6_q[c][31]}}, b2_6_q[c]} + {r3_q[c][47], r3_q[c]};
      snd[c]   = lvau_pkg::sat32({sum2[c][48], sum2[c]});
      if (c < lvau_pkg::Dims) begin
        nv_d[c] = cmd_q[6] ? snd[c] : fst_6_q[c];
        o_d[c]  = cmd_q[6] ? fst_6_q[c] : snd[c];
      end else begin
        // component not integrated: velocity and position or force pass through
        nv_d[c] = cmd_q[6] ? b2_6_q[c] : b1_6_q[c];
        o_d[c]  = cmd_q[6] ? b1_6_q[c] : b2_6_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NC; c++) begin
      if (accept) begin
        v1_q[c] <= vel_in[c];
        f1_q[c] <= frc_in[c];
        a1_q[c] <= aux_in[c];
      end
      if (vld_q[1]) begin
        p1_q[c]   <= p1_d[c];
        p2_q[c]   <= {{15{p2_w[c][48]}}, p2_w[c]};
        b1_2_q[c] <= cmd_q[1] ? f1_q[c] : v1_q[c];
        b2_2_q[c] <= cmd_q[1] ? v1_q[c] : a1_q[c];
      end
      if (vld_q[2]) begin
        r1_q[c]   <= lvau_pkg::round_q16(p1_q[c]);
        r2_q[c]   <= lvau_pkg::round_q16(p2_q[c]);
        b1_3_q[c] <= b1_2_q[c];
        b2_3_q[c] <= b2_2_q[c];
      end
      if (vld_q[3]) begin
        fst_4_q[c] <= lvau_pkg::sat32(sum1[c]);
        b1_4_q[c]  <= b1_3_q[c];
        b2_4_q[c]  <= b2_3_q[c];
      end
      if (vld_q[4]) begin
        p3_q[c]    <= p3_d[c];
        fst_5_q[c] <= fst_4_q[c];
        b1_5_q[c]  <= b1_4_q[c];
        b2_5_q[c]  <= b2_4_q[c];
      end
      if (vld_q[5]) begin
        r3_q[c]    <= lvau_pkg::round_q16(p3_q[c]);
        fst_6_q[c] <= fst_5_q[c];
        b1_6_q[c]  <= b1_5_q[c];
        b2_6_q[c]  <= b2_5_q[c];
      end
      if (vld_q[6]) begin
        nv_q[c] <= nv_d[c];
        o_q[c]  <= o_d[c];
      end
    end
  end

  assign done_o      = vld_q[lvau_pkg::Latency];
  assign new_vel_x_o = nv_q[0];
  assign new_vel_y_o = nv_q[1];
  assign new_vel_z_o = nv_q[2];
  assign out_x_o     = o_q[0];
  assign out_y_o     = o_q[1];
  assign out_z_o     = o_q[2];

  // ---------------- assertions ----------------
  `LVAU_ASSERT_LAT(a_result_follows, clk_i, rst_ni, start_i && !busy_o, 7, done_o,
                   "accepted transaction did not give a result after the pipeline latency")
  `LVAU_ASSERT_IMPL(a_result_has_cause, clk_i, rst_ni, done_o, $past(start_i && !busy_o, 7),
                    "result strobe without a transaction accepted at the pipeline latency")
  `LVAU_ASSERT_IMPL(a_cmd_held, clk_i, rst_ni, vld_q[5] && vld_q[6],
                    cmd_q[6] == $past(cmd_q[5]),
                    "command bit lost alignment with its data in the pipeline")

endmodule
